// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the purge valve sequencer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PVS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("purge valve sequencer assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("purge valve sequencer assertion failed");

`endif

// ===== rtl/core/pvs_pkg.sv =====
// ---------------------------------------------------------------------------
// pvs_pkg
// Types, constants and register map of the purge valve sequencer.
// ---------------------------------------------------------------------------
package pvs_pkg;

  localparam int VALVE_COUNT = 8;
  localparam int VALVE_IDX_W = 3;
  localparam int DRIVE_W     = 8;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;

  localparam logic [15:0] TICKS_PER_SECOND = 16'd1000;
  localparam logic [7:0]  LOCKOUT_TICKS    = 8'd200;
  localparam logic [VALVE_IDX_W:0] VALVE_LIMIT = (VALVE_IDX_W + 1)'(VALVE_COUNT);

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_PULSE = 2'd1,
    PH_PAUSE = 2'd2,
    PH_GAP   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    MODE_PRESSURE = 2'd0,
    MODE_TIMED    = 2'd1,
    MODE_BUTTON   = 2'd2,
    MODE_NEVER    = 2'd3
  } trig_mode_e;

  typedef enum logic [2:0] {
    REG_TRIGGER_MODE = 3'd0,
    REG_PULSE_TICKS  = 3'd1,
    REG_PAUSE_SEC    = 3'd2,
    REG_SERIES_SEC   = 3'd3,
    REG_PRESS_LIMIT  = 3'd4,
    REG_GAP_SEC      = 3'd5,
    REG_ROUNDS       = 3'd6
  } reg_idx_e;

  typedef struct packed {
    trig_mode_e  trigger_mode;
    logic [15:0] pulse_ticks;
    logic [15:0] pause_seconds;
    logic [15:0] series_seconds;
    logic [15:0] pressure_limit;
    logic [15:0] round_gap_seconds;
    logic [7:0]  rounds_per_series;
  } pvs_cfg_t;

  typedef struct packed {
    logic [DRIVE_W-1:0]     valve_drive;
    phase_e                 phase;
    logic [VALVE_IDX_W-1:0] valve_index;
    logic                   button_locked;
  } pvs_result_t;

endpackage

// ===== rtl/core/pvs_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// pvs_cfg_regs
// APB-style configuration registers of the purge valve sequencer.
// ---------------------------------------------------------------------------
module pvs_cfg_regs import pvs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output pvs_cfg_t              cfg_o
);

  pvs_cfg_t cfg_q;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_mode      <= MODE_BUTTON;
      cfg_q.pulse_ticks       <= 16'd300;
      cfg_q.pause_seconds     <= 16'd3;
      cfg_q.series_seconds    <= 16'(15 * 60);
      cfg_q.pressure_limit    <= 16'd0;
      cfg_q.round_gap_seconds <= 16'd0;
      cfg_q.rounds_per_series <= 8'd1;
    end else if (wr_en) begin
      case (paddr[APB_ADDR_W-1:2])
        REG_TRIGGER_MODE: cfg_q.trigger_mode      <= trig_mode_e'(pwdata[1:0]);
        REG_PULSE_TICKS:  cfg_q.pulse_ticks       <= pwdata[15:0];
        REG_PAUSE_SEC:    cfg_q.pause_seconds     <= pwdata[15:0];
        REG_SERIES_SEC:   cfg_q.series_seconds    <= pwdata[15:0];
        REG_PRESS_LIMIT:  cfg_q.pressure_limit    <= pwdata[15:0];
        REG_GAP_SEC:      cfg_q.round_gap_seconds <= pwdata[15:0];
        REG_ROUNDS:       cfg_q.rounds_per_series <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[APB_ADDR_W-1:2])
      REG_TRIGGER_MODE: prdata = APB_DATA_W'(cfg_q.trigger_mode);
      REG_PULSE_TICKS:  prdata = APB_DATA_W'(cfg_q.pulse_ticks);
      REG_PAUSE_SEC:    prdata = APB_DATA_W'(cfg_q.pause_seconds);
      REG_SERIES_SEC:   prdata = APB_DATA_W'(cfg_q.series_seconds);
      REG_PRESS_LIMIT:  prdata = APB_DATA_W'(cfg_q.pressure_limit);
      REG_GAP_SEC:      prdata = APB_DATA_W'(cfg_q.round_gap_seconds);
      REG_ROUNDS:       prdata = APB_DATA_W'(cfg_q.rounds_per_series);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/pvs_core.sv =====
// ---------------------------------------------------------------------------
// pvs_core
// Sequencer state and its per-tick update, registered on update_i.
// ---------------------------------------------------------------------------
module pvs_core import pvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pvs_cfg_t    cfg_i,
  input  logic        update_i,
  input  logic        tick_i,
  input  logic [15:0] pressure_i,
  input  logic        start_request_i,
  output pvs_result_t result_o
);

  phase_e                 phase_q, phase_d;
  logic [VALVE_IDX_W-1:0] valve_q, valve_d;
  logic [15:0]            tick_cnt_q, tick_cnt_d;
  logic [15:0]            sec_cnt_q, sec_cnt_d;
  logic [7:0]             round_cnt_q, round_cnt_d;
  logic                   lock_q, lock_d;
  logic [7:0]             lock_cnt_q, lock_cnt_d;
  logic [VALVE_IDX_W:0]   valve_inc;
  logic [7:0]             round_inc;
  logic                   sec_roll;

  always_comb begin
    phase_d     = phase_q;
    valve_d     = valve_q;
    tick_cnt_d  = tick_cnt_q;
    sec_cnt_d   = sec_cnt_q;
    round_cnt_d = round_cnt_q;
    lock_d      = lock_q;
    lock_cnt_d  = lock_cnt_q;
    valve_inc   = {1'b0, valve_q} + (VALVE_IDX_W + 1)'(1);
    round_inc   = round_cnt_q + 8'd1;
    sec_roll    = 1'b0;

    if (tick_i) begin
      tick_cnt_d = tick_cnt_q + 16'd1;
      sec_roll   = (tick_cnt_d >= TICKS_PER_SECOND);

      // Advance the button lockout; release once past its length.
      if (lock_q) begin
        lock_cnt_d = lock_cnt_q + 8'd1;
        if (lock_cnt_d > LOCKOUT_TICKS) begin
          lock_d     = 1'b0;
          lock_cnt_d = 8'd0;
        end
      end

      // Force the series wait to expire on high pressure.
      if (cfg_i.trigger_mode == MODE_PRESSURE && pressure_i > cfg_i.pressure_limit &&
          phase_q == PH_WAIT) begin
        sec_cnt_d = cfg_i.series_seconds;
      end

      case (phase_q)
        PH_WAIT: begin
          if (cfg_i.trigger_mode == MODE_TIMED && sec_roll) begin
            sec_cnt_d  = sec_cnt_d + 16'd1;
            tick_cnt_d = 16'd0;
          end
          if (sec_cnt_d >= cfg_i.series_seconds) begin
            phase_d    = PH_PULSE;
            sec_cnt_d  = 16'd0;
            tick_cnt_d = 16'd0;
          end
        end
        PH_GAP: begin
          if (sec_roll) begin
            sec_cnt_d  = sec_cnt_d + 16'd1;
            tick_cnt_d = 16'd0;
          end
          if (sec_cnt_d >= cfg_i.round_gap_seconds) begin
            phase_d    = PH_PULSE;
            sec_cnt_d  = 16'd0;
            tick_cnt_d = 16'd0;
          end
        end
        PH_PULSE: begin
          if (tick_cnt_d >= cfg_i.pulse_ticks) begin
            phase_d    = PH_PAUSE;
            tick_cnt_d = 16'd0;
          end
        end
        PH_PAUSE: begin
          if (sec_roll) begin
            sec_cnt_d  = sec_cnt_d + 16'd1;
            tick_cnt_d = 16'd0;
          end
          if (sec_cnt_d >= cfg_i.pause_seconds) begin
            // Step to the next valve; close the round after the last one.
            if ({1'b0, valve_inc[VALVE_IDX_W-1:0]} >= VALVE_LIMIT ||
                valve_inc[VALVE_IDX_W-1:0] == '0) begin
              valve_d = '0;
              if (round_inc < cfg_i.rounds_per_series) begin
                round_cnt_d = round_inc;
                phase_d     = PH_GAP;
              end else begin
                round_cnt_d = 8'd0;
                phase_d     = PH_WAIT;
              end
            end else begin
              valve_d = valve_inc[VALVE_IDX_W-1:0];
              phase_d = PH_PULSE;
            end
            sec_cnt_d = 16'd0;
          end
        end
        default: ;
      endcase

      // Forced purge: close all valves and start a series on the next tick.
      if (start_request_i && !lock_d &&
          (cfg_i.trigger_mode == MODE_TIMED || cfg_i.trigger_mode == MODE_BUTTON)) begin
        lock_d     = 1'b1;
        lock_cnt_d = 8'd0;
        phase_d    = PH_WAIT;
        sec_cnt_d  = cfg_i.series_seconds;
        valve_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      valve_q     <= '0;
      tick_cnt_q  <= 16'd0;
      sec_cnt_q   <= 16'd0;
      round_cnt_q <= 8'd0;
      lock_q      <= 1'b0;
      lock_cnt_q  <= 8'd0;
    end else if (update_i) begin
      phase_q     <= phase_d;
      valve_q     <= valve_d;
      tick_cnt_q  <= tick_cnt_d;
      sec_cnt_q   <= sec_cnt_d;
      round_cnt_q <= round_cnt_d;
      lock_q      <= lock_d;
      lock_cnt_q  <= lock_cnt_d;
    end
  end

  assign result_o.valve_drive   = (phase_d == PH_PULSE) ? (DRIVE_W'(1) << valve_d) : '0;
  assign result_o.phase         = phase_d;
  assign result_o.valve_index   = valve_d;
  assign result_o.button_locked = lock_d;

endmodule

// ===== rtl/core/purge_valve_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// purge_valve_sequencer_unit
// Top level: input register, sequencer update and result register.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one timer tick per
//   transaction with the latest pressure sample and the button flag. A
//   transaction with tick_i low leaves the state alone but still returns
//   a result showing the current state.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   transaction per input transaction, in order: valve drive, phase,
//   valve index and lockout flag, all taken after the update.
//   The input register captures the transaction at the accepting edge, and
//   out_valid_o rises when the result register loads it from pvs_core.
//   One transaction per cycle is sustained while the receiver does not stall;
//   the rate is set by the state update loop in pvs_core.
//   When the receiver stalls, the result register holds its transaction,
//   the input register fills, and then in_stall_o rises; no transaction
//   is lost or repeated.
//   Reset (rst_ni low) clears all sequencer state and the valid flags of
//   both pipeline registers and loads the register defaults; no sweep
//   follows, so a transaction may be accepted as soon as rst_ni rises.
//   Write configuration over the APB port only while the block is idle.
// ---------------------------------------------------------------------------
module purge_valve_sequencer_unit import pvs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   tick_i,
  input  logic [15:0]            pressure_i,
  input  logic                   start_request_i,
  // output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DRIVE_W-1:0]     valve_drive_o,
  output logic [1:0]             phase_o,
  output logic [VALVE_IDX_W-1:0] valve_index_o,
  output logic                   button_locked_o
);

  pvs_cfg_t    cfg;
  pvs_result_t core_res;

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic        s1_tick_q;
  logic [15:0] s1_pressure_q;
  logic        s1_start_q;

  // result register
  logic        out_valid_q, out_valid_d;
  pvs_result_t out_res_q;

  logic        in_accept;
  logic        advance;

  pvs_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move the held transaction forward whenever the result register is
  // free or is being drained this cycle.
  assign advance    = s1_valid_q & ~(out_valid_q & out_stall_i);
  assign in_stall_o = s1_valid_q & ~advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  pvs_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .update_i        (advance),
    .tick_i          (s1_tick_q),
    .pressure_i      (s1_pressure_q),
    .start_request_i (s1_start_q),
    .result_o        (core_res)
  );

  always_comb begin
    s1_valid_d  = in_accept | (s1_valid_q & ~advance);
    out_valid_d = advance | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input payload only on acceptance and the result only on advance; hold both otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_tick_q     <= tick_i;
      s1_pressure_q <= pressure_i;
      s1_start_q    <= start_request_i;
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign valve_drive_o   = out_res_q.valve_drive;
  assign phase_o         = out_res_q.phase;
  assign valve_index_o   = out_res_q.valve_index;
  assign button_locked_o = out_res_q.button_locked;

endmodule

// ===== rtl/core/pvs_checker.sv =====
// ---------------------------------------------------------------------------
// pvs_checker
// Port-level assertions for the purge valve sequencer, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pvs_checker import pvs_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [DRIVE_W-1:0]     valve_drive_o,
  input logic [1:0]             phase_o,
  input logic [VALVE_IDX_W-1:0] valve_index_o
);

  // Drive follows the valve index while pulsing.
  `PVS_ASSERT_NOW(a_pulse_drive, out_valid_o && phase_o == PH_PULSE,
                  valve_drive_o == (DRIVE_W'(1) << valve_index_o))

  // All valves closed outside the pulse phase.
  `PVS_ASSERT_NOW(a_closed_idle, out_valid_o && phase_o != PH_PULSE, valve_drive_o == '0)

  // Backpressure reaches the input only through a stalled held result.
  `PVS_ASSERT_NOW(a_stall_source, in_stall_o, out_valid_o && out_stall_i)

  // A stalled result stays put.
  `PVS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(valve_drive_o) && $stable(phase_o) &&
                   $stable(valve_index_o))

endmodule

bind purge_valve_sequencer_unit pvs_checker u_pvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .valve_drive_o (valve_drive_o),
  .phase_o       (phase_o),
  .valve_index_o (valve_index_o)
);

// ===== tb/purge_valve_sequence_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// purge_valve_sequence_checker
// Follows register writes and accepted tick transactions, steps its own copy
// of the valve sequencer, and checks every result transaction field by field
// against the oldest predicted status.
// ----------------------------------------------------------------------------
module purge_valve_sequence_checker import pvs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic [APB_ADDR_W-1:0]  paddr_i,
  input  logic [APB_DATA_W-1:0]  pwdata_i,
  input  logic                   pready_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   tick_i,
  input  logic [15:0]            pressure_i,
  input  logic                   start_request_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [DRIVE_W-1:0]     valve_drive_i,
  input  logic [1:0]             phase_i,
  input  logic [VALVE_IDX_W-1:0] valve_index_i,
  input  logic                   button_locked_i,
  output int                     mismatch_count_o,
  output int                     pending_o
);

  pvs_cfg_t               cfg;
  phase_e                 phase_q;
  logic [VALVE_IDX_W-1:0] valve_q;
  logic [15:0]            tick_q;
  logic [15:0]            sec_q;
  logic [7:0]             round_q;
  logic                   lock_q;
  logic [7:0]             lock_cnt_q;
  pvs_result_t            valve_status_q[$];
  int                     mismatch_count;

  // Carry a full second of ticks into the seconds count.
  function automatic void roll_second();
    if (tick_q >= TICKS_PER_SECOND) begin
      sec_q  = sec_q + 16'd1;
      tick_q = '0;
    end
  endfunction

  function automatic pvs_result_t step_sequencer(input logic        tick,
                                                 input logic [15:0] pressure,
                                                 input logic        start);
    pvs_result_t          status;
    logic [VALVE_IDX_W:0] next_valve;
    if (tick) begin
      tick_q = tick_q + 16'd1;
      if (lock_q) begin
        lock_cnt_q = lock_cnt_q + 8'd1;
        if (lock_cnt_q > LOCKOUT_TICKS) begin
          lock_q     = 1'b0;
          lock_cnt_q = '0;
        end
      end
      if (cfg.trigger_mode == MODE_PRESSURE && pressure > cfg.pressure_limit &&
          phase_q == PH_WAIT) begin
        sec_q = cfg.series_seconds;
      end
      case (phase_q)
        PH_WAIT: begin
          if (cfg.trigger_mode == MODE_TIMED) roll_second();
          if (sec_q >= cfg.series_seconds) begin
            phase_q = PH_PULSE;
            sec_q   = '0;
            tick_q  = '0;
          end
        end
        PH_GAP: begin
          roll_second();
          if (sec_q >= cfg.round_gap_seconds) begin
            phase_q = PH_PULSE;
            sec_q   = '0;
            tick_q  = '0;
          end
        end
        PH_PULSE: begin
          if (tick_q >= cfg.pulse_ticks) begin
            phase_q = PH_PAUSE;
            tick_q  = '0;
          end
        end
        default: begin
          // Pause: tick_q keeps running across the end of the pause.
          roll_second();
          if (sec_q >= cfg.pause_seconds) begin
            next_valve = {1'b0, valve_q} + 1'b1;
            if (next_valve >= VALVE_LIMIT || next_valve[VALVE_IDX_W-1:0] == '0) begin
              valve_q = '0;
              round_q = round_q + 8'd1;
              if (round_q < cfg.rounds_per_series) begin
                phase_q = PH_GAP;
              end else begin
                round_q = '0;
                phase_q = PH_WAIT;
              end
            end else begin
              valve_q = next_valve[VALVE_IDX_W-1:0];
              phase_q = PH_PULSE;
            end
            sec_q = '0;
          end
        end
      endcase
      // Button: close everything and arm the series; round_q is left alone.
      if (start && !lock_q &&
          (cfg.trigger_mode == MODE_TIMED || cfg.trigger_mode == MODE_BUTTON)) begin
        lock_q     = 1'b1;
        lock_cnt_q = '0;
        phase_q    = PH_WAIT;
        sec_q      = cfg.series_seconds;
        valve_q    = '0;
      end
    end
    status.valve_drive   = (phase_q == PH_PULSE) ? (DRIVE_W'(1) << valve_q) : '0;
    status.phase         = phase_q;
    status.valve_index   = valve_q;
    status.button_locked = lock_q;
    return status;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pvs_result_t want;
    if (!rst_ni) begin
      cfg.trigger_mode      = MODE_BUTTON;
      cfg.pulse_ticks       = 16'd300;
      cfg.pause_seconds     = 16'd3;
      cfg.series_seconds    = 16'd900;
      cfg.pressure_limit    = 16'd0;
      cfg.round_gap_seconds = 16'd0;
      cfg.rounds_per_series = 8'd1;
      phase_q        = PH_WAIT;
      valve_q        = '0;
      tick_q         = '0;
      sec_q          = '0;
      round_q        = '0;
      lock_q         = 1'b0;
      lock_cnt_q     = '0;
      mismatch_count = 0;
      valve_status_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_ADDR_W-1:2])
          REG_TRIGGER_MODE: cfg.trigger_mode      = trig_mode_e'(pwdata_i[1:0]);
          REG_PULSE_TICKS:  cfg.pulse_ticks       = pwdata_i[15:0];
          REG_PAUSE_SEC:    cfg.pause_seconds     = pwdata_i[15:0];
          REG_SERIES_SEC:   cfg.series_seconds    = pwdata_i[15:0];
          REG_PRESS_LIMIT:  cfg.pressure_limit    = pwdata_i[15:0];
          REG_GAP_SEC:      cfg.round_gap_seconds = pwdata_i[15:0];
          REG_ROUNDS:       cfg.rounds_per_series = pwdata_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (valve_status_q.size() == 0) begin
          $display("%0t: result transaction with no prediction pending", $time);
          mismatch_count++;
        end else begin
          want = valve_status_q.pop_front();
          if (valve_drive_i !== want.valve_drive) begin
            $display("%0t: valve_drive expected %h actual %h",
                     $time, want.valve_drive, valve_drive_i);
            mismatch_count++;
          end
          if (phase_i !== want.phase) begin
            $display("%0t: phase expected %0d actual %0d", $time, want.phase, phase_i);
            mismatch_count++;
          end
          if (valve_index_i !== want.valve_index) begin
            $display("%0t: valve_index expected %0d actual %0d",
                     $time, want.valve_index, valve_index_i);
            mismatch_count++;
          end
          if (button_locked_i !== want.button_locked) begin
            $display("%0t: button_locked expected %b actual %b",
                     $time, want.button_locked, button_locked_i);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        valve_status_q.push_back(step_sequencer(tick_i, pressure_i, start_request_i));
      end
    end
    pending_o        <= valve_status_q.size();
    mismatch_count_o <= mismatch_count;
  end

endmodule

// ===== tb/purge_valve_sequencer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// purge_valve_sequencer_unit_tb
// Drives tick transactions and register writes into the purge valve
// sequencer with random sender gaps and receiver stalls; a checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module purge_valve_sequencer_unit_tb;
  import pvs_pkg::*;

  // Upper bound on the run length, with plenty of margin.
  localparam int CYCLE_LIMIT = 3_000_000;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr       = '0;
  logic [APB_DATA_W-1:0]  pwdata      = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic                   tick        = 1'b0;
  logic [15:0]            pressure    = '0;
  logic                   start_req   = 1'b0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [DRIVE_W-1:0]     valve_drive;
  logic [1:0]             phase;
  logic [VALVE_IDX_W-1:0] valve_index;
  logic                   button_locked;

  int          mismatches;
  int          pending;
  int          cycles       = 0;
  bit          idle_en      = 1'b1;   // sender inserts gaps
  bit          stall_en     = 1'b1;   // receiver inserts stalls
  logic [15:0] limit_shadow = '0;     // steer pressure samples around the limit

  purge_valve_sequencer_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .tick_i          (tick),
    .pressure_i      (pressure),
    .start_request_i (start_req),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .valve_drive_o   (valve_drive),
    .phase_o         (phase),
    .valve_index_o   (valve_index),
    .button_locked_o (button_locked)
  );

  purge_valve_sequence_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .tick_i           (tick),
    .pressure_i       (pressure),
    .start_request_i  (start_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .valve_drive_i    (valve_drive),
    .phase_i          (phase),
    .valve_index_i    (valve_index),
    .button_locked_i  (button_locked),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[purge_valve_sequencer_unit] ERROR");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then a long stretch.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: alternate free runs and stall runs of random length.
  initial begin : out_stall_gen
    forever begin
      repeat (idle_length() + 1) @(posedge clk);
      if (stall_en) begin
        out_stall <= 1'b1;
        repeat (idle_length() + 1) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one tick transaction and hold it until accepted.
  task automatic send_item(input logic t, input logic [15:0] p, input logic s);
    int gap;
    gap = idle_en ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    tick      <= t;
    pressure  <= p;
    start_req <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain every outstanding result, then do one register write.
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input trig_mode_e mode, input logic [15:0] pulse,
                           input logic [15:0] pause, input logic [15:0] series,
                           input logic [15:0] limit, input logic [15:0] gap,
                           input logic [7:0] rounds);
    write_reg(REG_TRIGGER_MODE, 16'(mode));
    write_reg(REG_PULSE_TICKS, pulse);
    write_reg(REG_PAUSE_SEC, pause);
    write_reg(REG_SERIES_SEC, series);
    write_reg(REG_PRESS_LIMIT, limit);
    write_reg(REG_GAP_SEC, gap);
    write_reg(REG_ROUNDS, 16'(rounds));
    limit_shadow = limit;
  endtask

  // Random ticks: about one in ten carries no tick; the button fires at the
  // given rate in permille; half the pressure samples sit within one of the limit.
  task automatic run_items(input int n, input int start_permille);
    logic [15:0] p;
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) p = limit_shadow + 16'($urandom_range(0, 2)) - 16'd1;
      else p = 16'($urandom);
      send_item($urandom_range(0, 9) != 0, p, $urandom_range(0, 999) < start_permille);
    end
  endtask

  // Seconds-based lengths: mostly zero or one second, rarely the maximum.
  function automatic logic [15:0] pick_seconds();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'd0;
    if (r < 95) return 16'd1;
    if (r < 98) return 16'd2;
    return 16'hFFFF;
  endfunction

  initial begin : stimulus
    logic [15:0] pulse;
    logic [15:0] limit;
    logic [7:0]  rounds;
    int          r;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no-tick transactions leave state alone, even with the button; then one tick.
    send_item(1'b0, 16'h0000, 1'b1);
    send_item(1'b0, 16'hFFFF, 1'b0);
    send_item(1'b1, 16'hFFFF, 1'b0);

    // Zero pulse, pause and gap last one tick; zero rounds act as one round.
    configure(MODE_BUTTON, 16'd0, 16'd0, 16'd900, 16'd0, 16'd0, 8'd0);
    send_item(1'b1, 16'h0000, 1'b1);   // press: lock out, arm the series
    send_item(1'b1, 16'h0000, 1'b1);   // press during lockout is dropped
    repeat (17) send_item(1'b1, 16'($urandom), 1'b0);

    // Zero series wait starts a series even when triggering is disabled.
    configure(MODE_NEVER, 16'd5, 16'd0, 16'd0, 16'hFFFF, 16'd0, 8'd1);
    repeat (4) send_item(1'b1, 16'hFFFF, 1'b1);

    // Let the tick count run free in series wait, then switch to timed
    // mode mid-wait so the carried count decides the first second.
    idle_en  = 1'b0;
    stall_en = 1'b0;
    configure(MODE_NEVER, 16'd3, 16'd0, 16'd5, 16'd0, 16'd0, 8'd1);
    repeat (200) send_item(1'b1, 16'($urandom), 1'($urandom));
    idle_en  = 1'b1;
    stall_en = 1'b1;
    configure(MODE_TIMED, 16'd3, 16'd0, 16'd1, 16'd0, 16'd0, 8'd2);
    run_items(300, 10);

    // All registers at their top: nothing can start in pressure mode ...
    configure(MODE_PRESSURE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_items(60, 0);
    // ... but the button still forces a series with the longest pulse.
    write_reg(REG_TRIGGER_MODE, 16'(MODE_BUTTON));
    run_items(60, 100);

    // A long run of rounds back to back at the shortest lengths.
    idle_en  = 1'b0;
    stall_en = 1'b0;
    configure(MODE_NEVER, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'hFF);
    run_items(300, 0);

    // Random settings; some phases run without sender gaps or stalls.
    repeat (6) begin
      r = $urandom_range(0, 99);
      if (r < 35) pulse = 16'd0;
      else if (r < 75) pulse = 16'($urandom_range(1, 6));
      else if (r < 97) pulse = 16'($urandom_range(7, 400));
      else pulse = 16'hFFFF;
      r = $urandom_range(0, 99);
      if (r < 20) limit = 16'd0;
      else if (r < 50) limit = 16'($urandom_range(1, 16));
      else if (r < 80) limit = 16'($urandom);
      else limit = 16'hFFFF;
      r = $urandom_range(0, 99);
      if (r < 80) rounds = 8'($urandom_range(0, 3));
      else if (r < 90) rounds = 8'hFF;
      else rounds = 8'($urandom);
      configure(trig_mode_e'($urandom_range(0, 3)), pulse, pick_seconds(),
                pick_seconds(), limit, pick_seconds(), rounds);
      idle_en  = $urandom_range(0, 3) != 0;
      stall_en = $urandom_range(0, 3) != 0;
      run_items($urandom_range(120, 200), ($urandom_range(0, 4) == 0) ? 0 : 20);
    end

    // Drain and give the pipeline its latency before the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[purge_valve_sequencer_unit] OK");
    end else begin
      $display("[purge_valve_sequencer_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== purge_valve_sequencer_unit.f =====
+incdir+rtl/core
rtl/core/pvs_pkg.sv
rtl/core/pvs_cfg_regs.sv
rtl/core/pvs_core.sv
rtl/core/purge_valve_sequencer_unit.sv
rtl/core/pvs_checker.sv
tb/purge_valve_sequence_checker.sv
tb/purge_valve_sequencer_unit_tb.sv
